[sv/process_admission_scheduler_macros.svh]
// assertion macros for the process admission scheduler checker
// no dependencies; included by the checker file
`ifndef PROCESS_ADMISSION_SCHEDULER_MACROS_SVH
`define PROCESS_ADMISSION_SCHEDULER_MACROS_SVH

// same-cycle implication
`define PAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pas_pkg.sv]
// shared types and constants for the process admission scheduler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pas_pkg;

    localparam int ID_W   = 16;
    localparam int MEM_W  = 16;
    localparam int JOB_W  = ID_W + MEM_W;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 3;

    localparam int RUN_DEPTH_DEF  = 16;
    localparam int WAIT_DEPTH_DEF = 16;

    localparam logic [CNT_W-1:0] MAX_RUNNING_RESET  = 5'd4;
    localparam logic [MEM_W-1:0] MEMORY_TOTAL_RESET = 16'd1024;

    typedef enum logic {
        OP_CREATE = 1'b0,
        OP_KILL   = 1'b1
    } t_opcode;

    typedef enum logic {
        CFG_MAX_RUNNING  = 1'b0,
        CFG_MEMORY_TOTAL = 1'b1
    } t_cfg_index;

    typedef enum logic [STAT_W-1:0] {
        ST_RUNNING    = 3'd0,
        ST_WAITING    = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_WAIT_FULL  = 3'd3,
        ST_KILLED     = 3'd4,
        ST_NO_RUNNING = 3'd5
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   affected_id;
        logic              promoted;
        logic [ID_W-1:0]   promoted_id;
        logic [MEM_W-1:0]  mem_in_use;
        logic [CNT_W-1:0]  running_count;
        logic [CNT_W-1:0]  waiting_count;
    } t_result;

endpackage

[sv/process_admission_scheduler.sv]
// process admission scheduler top level: input stage, config, queues, result stage
// depends on pas_pkg, pas_fifo, pas_admit
//
// usage
//   input channel: i_valid / o_stall carry one request item (opcode, job id,
//   memory demand); an item is taken at a clock edge with i_valid high and
//   o_stall low
//   output channel: o_valid / i_stall carry one result item per request
//   config: i_cfg_we writes i_cfg_wdata to register i_cfg_index (0 max_running,
//   1 memory_total); the user must write only while the block is idle (not enforced)
//   result: a taken item is held in the input stage, and its result is registered
//   into the output stage; throughput: one item per cycle while the result is not
//   stalled; the queue heads are prefetched into registers, so back-to-back kills do not wait
//   stall: a held result stays stable; one more item is taken into the input
//   stage, after which o_stall rises until the result is taken
//   reset: both queues empty, memory in use zero, max_running 4,
//   memory_total 1024; queue storage is not cleared
`timescale 1ns / 1ps

module process_admission_scheduler import pas_pkg::*; #(
    parameter int RUN_DEPTH  = RUN_DEPTH_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_opcode,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [MEM_W-1:0]  i_mem_demand,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_affected_id,
    output logic              o_promoted,
    output logic [ID_W-1:0]   o_promoted_id,
    output logic [MEM_W-1:0]  o_mem_in_use,
    output logic [CNT_W-1:0]  o_running_count,
    output logic [CNT_W-1:0]  o_waiting_count,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [MEM_W-1:0]  i_cfg_wdata
);

    localparam int RCW = $clog2(RUN_DEPTH + 1);
    localparam int WCW = $clog2(WAIT_DEPTH + 1);

    logic             r_in_valid;
    t_opcode          r_in_opcode;
    logic [ID_W-1:0]  r_in_job_id;
    logic [MEM_W-1:0] r_in_mem_demand;
    logic             r_out_valid;
    t_result          r_out;
    logic [CNT_W-1:0] r_max_running;
    logic [MEM_W-1:0] r_memory_total;
    logic [MEM_W-1:0] r_mem_used;

    logic             w_advance;
    logic             w_accept;
    logic             w_proc;
    t_q_ctrl          w_run_ctrl;
    t_q_ctrl          w_wait_ctrl;
    logic [JOB_W-1:0] w_run_push_job;
    logic [JOB_W-1:0] w_new_job;
    logic [JOB_W-1:0] w_run_head_job;
    logic [JOB_W-1:0] w_wait_head_job;
    logic [RCW-1:0]   w_run_count;
    logic [WCW-1:0]   w_wait_count;
    logic [MEM_W-1:0] n_mem_used;
    t_result          n_out;

    assign w_advance = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;
    assign w_proc    = r_in_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_opcode     <= t_opcode'(i_opcode);
            r_in_job_id     <= i_job_id;
            r_in_mem_demand <= i_mem_demand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_running  <= MAX_RUNNING_RESET;
            r_memory_total <= MEMORY_TOTAL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MAX_RUNNING:  r_max_running  <= i_cfg_wdata[CNT_W-1:0];
                CFG_MEMORY_TOTAL: r_memory_total <= i_cfg_wdata;
                default:          r_memory_total <= r_memory_total;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_used <= '0;
        end else if (w_proc) begin
            r_mem_used <= n_mem_used;
        end
    end

    pas_fifo #(.DEPTH(RUN_DEPTH)) u_run_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_run_ctrl),
        .i_push_job (w_run_push_job),
        .o_head_job (w_run_head_job),
        .o_count    (w_run_count)
    );

    pas_fifo #(.DEPTH(WAIT_DEPTH)) u_wait_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_wait_ctrl),
        .i_push_job (w_new_job),
        .o_head_job (w_wait_head_job),
        .o_count    (w_wait_count)
    );

    pas_admit #(
        .RUN_DEPTH  (RUN_DEPTH),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_admit (
        .i_valid         (w_proc),
        .i_opcode        (r_in_opcode),
        .i_job_id        (r_in_job_id),
        .i_mem_demand    (r_in_mem_demand),
        .i_max_running   (r_max_running),
        .i_memory_total  (r_memory_total),
        .i_mem_used      (r_mem_used),
        .i_run_count     (w_run_count),
        .i_wait_count    (w_wait_count),
        .i_run_head_job  (w_run_head_job),
        .i_wait_head_job (w_wait_head_job),
        .o_run_ctrl      (w_run_ctrl),
        .o_wait_ctrl     (w_wait_ctrl),
        .o_run_push_job  (w_run_push_job),
        .o_new_job       (w_new_job),
        .o_mem_used      (n_mem_used),
        .o_result        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_affected_id   = r_out.affected_id;
    assign o_promoted      = r_out.promoted;
    assign o_promoted_id   = r_out.promoted_id;
    assign o_mem_in_use    = r_out.mem_in_use;
    assign o_running_count = r_out.running_count;
    assign o_waiting_count = r_out.waiting_count;

endmodule

[sv/pas_fifo.sv]
// circular job queue with a prefetched head entry
// depends on pas_pkg
`timescale 1ns / 1ps

module pas_fifo import pas_pkg::*; #(
    parameter int DEPTH = RUN_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_ctrl          i_ctrl,
    input  logic [JOB_W-1:0] i_push_job,
    output logic [JOB_W-1:0] o_head_job,
    output logic [CW-1:0]    o_count
);

    logic [JOB_W-1:0] mem [DEPTH];
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [JOB_W-1:0] r_head_job;
    logic [AW:0]      w_sum;
    logic [AW-1:0]    w_waddr;

    // tail slot, wrapped for any depth
    assign w_sum   = (AW + 1)'(r_head) + (AW + 1)'(r_count);
    assign w_waddr = (w_sum >= (AW + 1)'(DEPTH)) ? AW'(w_sum - (AW + 1)'(DEPTH))
                                                 : AW'(w_sum);

    always_comb begin
        n_head = r_head;
        if (i_ctrl.pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        end
    end

    always_comb begin
        unique case ({i_ctrl.push, i_ctrl.pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[w_waddr] <= i_push_job;
        end
    end

    // head entry for the next item, with write bypass
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && (w_waddr == n_head)) begin
            r_head_job <= i_push_job;
        end else begin
            r_head_job <= mem[n_head];
        end
    end

    assign o_head_job = r_head_job;
    assign o_count    = r_count;

endmodule

[sv/pas_admit.sv]
// admission and kill decision for one item, queue controls and result fields
// depends on pas_pkg
`timescale 1ns / 1ps

module pas_admit import pas_pkg::*; #(
    parameter int RUN_DEPTH  = RUN_DEPTH_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    localparam int RCW = $clog2(RUN_DEPTH + 1),
    localparam int WCW = $clog2(WAIT_DEPTH + 1)
) (
    input  logic             i_valid,
    input  t_opcode          i_opcode,
    input  logic [ID_W-1:0]  i_job_id,
    input  logic [MEM_W-1:0] i_mem_demand,
    input  logic [CNT_W-1:0] i_max_running,
    input  logic [MEM_W-1:0] i_memory_total,
    input  logic [MEM_W-1:0] i_mem_used,
    input  logic [RCW-1:0]   i_run_count,
    input  logic [WCW-1:0]   i_wait_count,
    input  logic [JOB_W-1:0] i_run_head_job,
    input  logic [JOB_W-1:0] i_wait_head_job,
    output t_q_ctrl          o_run_ctrl,
    output t_q_ctrl          o_wait_ctrl,
    output logic [JOB_W-1:0] o_run_push_job,
    output logic [JOB_W-1:0] o_new_job,
    output logic [MEM_W-1:0] o_mem_used,
    output t_result          o_result
);

    localparam int SCW = (RCW > CNT_W) ? RCW : CNT_W;

    logic             w_too_large;
    logic             w_slot;
    logic             w_fits;
    logic             w_wait_room;
    logic [MEM_W-1:0] w_freed;
    logic [MEM_W-1:0] w_mem_after;
    logic [MEM_W-1:0] w_need;
    logic             w_promote;
    logic [RCW-1:0]   w_run_next;
    logic [WCW-1:0]   w_wait_next;

    assign o_new_job   = {i_job_id, i_mem_demand};
    assign w_too_large = i_mem_demand > i_memory_total;
    assign w_slot      = (SCW'(i_run_count) < SCW'(i_max_running))
                      && (i_run_count < RCW'(RUN_DEPTH));
    assign w_fits      = (i_mem_used <= i_memory_total)
                      && (({1'b0, i_mem_used} + {1'b0, i_mem_demand})
                          <= {1'b0, i_memory_total});
    assign w_wait_room = i_wait_count < WCW'(WAIT_DEPTH);

    // kill path: saturating release, then head-of-wait promotion check
    assign w_freed     = i_run_head_job[MEM_W-1:0];
    assign w_mem_after = (i_mem_used >= w_freed) ? i_mem_used - w_freed : '0;
    assign w_need      = i_wait_head_job[MEM_W-1:0];
    assign w_promote   = (i_wait_count != '0)
                      && (({1'b0, w_need} + {1'b0, w_mem_after})
                          <= {1'b0, i_memory_total});

    always_comb begin
        o_run_ctrl           = '0;
        o_wait_ctrl          = '0;
        o_run_push_job       = o_new_job;
        o_mem_used           = i_mem_used;
        o_result             = '0;
        o_result.status      = ST_NO_RUNNING;
        o_result.affected_id = '0;
        o_result.promoted    = 1'b0;
        o_result.promoted_id = '0;
        priority if (i_opcode == OP_CREATE) begin
            o_result.affected_id = i_job_id;
            priority if (w_too_large) begin
                o_result.status = ST_TOO_LARGE;
            end else if (w_slot && w_fits) begin
                o_run_ctrl.push = i_valid;
                o_mem_used      = i_mem_used + i_mem_demand;
                o_result.status = ST_RUNNING;
            end else if (w_wait_room) begin
                o_wait_ctrl.push = i_valid;
                o_result.status  = ST_WAITING;
            end else begin
                o_result.status = ST_WAIT_FULL;
            end
        end else if (i_run_count == '0) begin
            o_result.status = ST_NO_RUNNING;
        end else begin
            o_run_ctrl.pop       = i_valid;
            o_mem_used           = w_mem_after;
            o_result.status      = ST_KILLED;
            o_result.affected_id = i_run_head_job[JOB_W-1:MEM_W];
            if (w_promote) begin
                o_wait_ctrl.pop      = i_valid;
                o_run_ctrl.push      = i_valid;
                o_run_push_job       = i_wait_head_job;
                o_mem_used           = w_mem_after + w_need;
                o_result.promoted    = 1'b1;
                o_result.promoted_id = i_wait_head_job[JOB_W-1:MEM_W];
            end
        end

        w_run_next = i_run_count;
        if (o_run_ctrl.push && !o_run_ctrl.pop) begin
            w_run_next = i_run_count + RCW'(1);
        end else if (!o_run_ctrl.push && o_run_ctrl.pop) begin
            w_run_next = i_run_count - RCW'(1);
        end
        w_wait_next = i_wait_count;
        if (o_wait_ctrl.push) begin
            w_wait_next = i_wait_count + WCW'(1);
        end else if (o_wait_ctrl.pop) begin
            w_wait_next = i_wait_count - WCW'(1);
        end

        o_result.mem_in_use    = o_mem_used;
        o_result.running_count = CNT_W'(w_run_next);
        o_result.waiting_count = CNT_W'(w_wait_next);
    end

endmodule

[sv/pas_checker.sv]
// port-level checks for the process admission scheduler, bound to the top level
// depends on pas_pkg and process_admission_scheduler_macros.svh
`timescale 1ns / 1ps
`include "process_admission_scheduler_macros.svh"

module pas_checker import pas_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [STAT_W-1:0] o_status,
    input logic [ID_W-1:0]   o_affected_id,
    input logic              o_promoted,
    input logic [ID_W-1:0]   o_promoted_id,
    input logic [MEM_W-1:0]  o_mem_in_use,
    input logic [CNT_W-1:0]  o_running_count
);

    logic w_create_status;

    assign w_create_status = (o_status == ST_RUNNING) || (o_status == ST_WAITING)
                          || (o_status == ST_TOO_LARGE) || (o_status == ST_WAIT_FULL);

    `PAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_affected_id) && $stable(o_mem_in_use), "stalled item changed")
    `PAS_ASSERT_NOW(a_create_no_promo, i_clk, i_rst_n, o_valid && w_create_status, !o_promoted, "promotion on a create item")
    `PAS_ASSERT_NOW(a_promo_id_zero, i_clk, i_rst_n, o_valid && !o_promoted, o_promoted_id == '0, "promoted id set without promotion")
    `PAS_ASSERT_NOW(a_none_to_kill, i_clk, i_rst_n, o_valid && (o_status == ST_NO_RUNNING), (o_affected_id == '0) && (o_running_count == '0), "empty kill with nonzero fields")

endmodule

bind process_admission_scheduler pas_checker u_pas_checker (.*);

[tb/sv/pas_outcome_checker.sv]
// checker for the process admission scheduler: keeps its own copy of both job queues,
// the memory count and the two limits, predicts every result item and compares it
// depends on pas_pkg; instantiated next to the block by process_admission_scheduler_test
`timescale 1ns / 1ps

module pas_outcome_checker import pas_pkg::*; #(
    parameter int RUN_DEPTH  = RUN_DEPTH_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_stall,
    input  logic              i_opcode,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [MEM_W-1:0]  i_mem_demand,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic [STAT_W-1:0] i_status,
    input  logic [ID_W-1:0]   i_affected_id,
    input  logic              i_promoted,
    input  logic [ID_W-1:0]   i_promoted_id,
    input  logic [MEM_W-1:0]  i_mem_in_use,
    input  logic [CNT_W-1:0]  i_running_count,
    input  logic [CNT_W-1:0]  i_waiting_count,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [MEM_W-1:0]  i_cfg_wdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [MEM_W-1:0] demand;
    } t_job;

    t_job             running_jobs[$];
    t_job             waiting_jobs[$];
    t_result          predicted_outcomes[$];
    logic [CNT_W-1:0] run_limit;
    logic [MEM_W-1:0] mem_capacity;
    logic [MEM_W-1:0] mem_held;
    int               mismatches = 0;
    int               results_seen = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = results_seen;

    function automatic t_result schedule_request(input t_opcode op, input logic [ID_W-1:0] id,
                                                 input logic [MEM_W-1:0] demand);
        t_result        r;
        t_job           victim;
        t_job           head;
        logic [MEM_W:0] sum;
        r = '0;
        if (op == OP_CREATE) begin
            r.affected_id = id;
            if (demand > mem_capacity) begin
                r.status = ST_TOO_LARGE;
            end else begin
                sum = {1'b0, mem_held} + demand;
                if (running_jobs.size() < run_limit && running_jobs.size() < RUN_DEPTH &&
                    mem_held <= mem_capacity && sum <= mem_capacity) begin
                    running_jobs.push_back('{id: id, demand: demand});
                    mem_held = sum[MEM_W-1:0];
                    r.status = ST_RUNNING;
                end else if (waiting_jobs.size() < WAIT_DEPTH) begin
                    waiting_jobs.push_back('{id: id, demand: demand});
                    r.status = ST_WAITING;
                end else begin
                    r.status = ST_WAIT_FULL;
                end
            end
        end else if (running_jobs.size() == 0) begin
            r.status = ST_NO_RUNNING;
        end else begin
            victim = running_jobs.pop_front();
            mem_held = (mem_held >= victim.demand) ? mem_held - victim.demand : '0;
            r.affected_id = victim.id;
            r.status = ST_KILLED;
            // promotion looks at memory only, not at the slot limit
            if (waiting_jobs.size() != 0) begin
                head = waiting_jobs[0];
                sum = {1'b0, mem_held} + head.demand;
                if (sum <= mem_capacity) begin
                    void'(waiting_jobs.pop_front());
                    running_jobs.push_back(head);
                    mem_held = sum[MEM_W-1:0];
                    r.promoted = 1'b1;
                    r.promoted_id = head.id;
                end
            end
        end
        r.mem_in_use    = mem_held;
        r.running_count = CNT_W'(running_jobs.size());
        r.waiting_count = CNT_W'(waiting_jobs.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] seen);
        if (mismatches < 40)
            $display("%0t ns result %0d: %s expected %0h got %0h",
                     $time, results_seen, what, want, seen);
        mismatches++;
    endtask

    task automatic compare_outcome(input t_result want);
        if (i_status !== want.status)
            report_mismatch("status", want.status, i_status);
        if (i_affected_id !== want.affected_id)
            report_mismatch("affected_id", want.affected_id, i_affected_id);
        if (i_promoted !== want.promoted)
            report_mismatch("promoted", want.promoted, i_promoted);
        if (i_promoted_id !== want.promoted_id)
            report_mismatch("promoted_id", want.promoted_id, i_promoted_id);
        if (i_mem_in_use !== want.mem_in_use)
            report_mismatch("mem_in_use", want.mem_in_use, i_mem_in_use);
        if (i_running_count !== want.running_count)
            report_mismatch("running_count", want.running_count, i_running_count);
        if (i_waiting_count !== want.waiting_count)
            report_mismatch("waiting_count", want.waiting_count, i_waiting_count);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            running_jobs.delete();
            waiting_jobs.delete();
            predicted_outcomes.delete();
            run_limit    = MAX_RUNNING_RESET;
            mem_capacity = MEMORY_TOTAL_RESET;
            mem_held     = '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_MAX_RUNNING:  run_limit = i_cfg_wdata[CNT_W-1:0];
                    CFG_MEMORY_TOTAL: mem_capacity = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall)
                predicted_outcomes.push_back(
                    schedule_request(t_opcode'(i_opcode), i_job_id, i_mem_demand));
            if (i_res_valid && !i_res_stall) begin
                if (predicted_outcomes.size() == 0) begin
                    report_mismatch("result item with nothing expected", '0, '0);
                end else begin
                    want = predicted_outcomes.pop_front();
                    compare_outcome(want);
                end
                results_seen++;
            end
        end
        o_pending <= predicted_outcomes.size();
    end

endmodule

[tb/sv/process_admission_scheduler_test.sv]
// testbench top for the process admission scheduler: clock, reset, request and limit
// stimulus, a stalling result sink, and the verdict
// depends on pas_pkg, process_admission_scheduler and pas_outcome_checker
`timescale 1ns / 1ps

module process_admission_scheduler_test;
    import pas_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    t_opcode           opcode = OP_CREATE;
    logic [ID_W-1:0]   job_id = '0;
    logic [MEM_W-1:0]  mem_demand = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   affected_id;
    logic              promoted;
    logic [ID_W-1:0]   promoted_id;
    logic [MEM_W-1:0]  mem_in_use;
    logic [CNT_W-1:0]  running_count;
    logic [CNT_W-1:0]  waiting_count;
    logic              cfg_we = 1'b0;
    t_cfg_index        cfg_index = CFG_MAX_RUNNING;
    logic [MEM_W-1:0]  cfg_wdata = '0;

    int                fail_count;
    int                pending;
    int                checked;
    int                requests_sent = 0;
    int                settings_applied = 0;
    logic [MEM_W-1:0]  cur_capacity = MEMORY_TOTAL_RESET;
    bit                steady_sender = 1'b0;

    process_admission_scheduler u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_opcode        (opcode),
        .i_job_id        (job_id),
        .i_mem_demand    (mem_demand),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_status        (status),
        .o_affected_id   (affected_id),
        .o_promoted      (promoted),
        .o_promoted_id   (promoted_id),
        .o_mem_in_use    (mem_in_use),
        .o_running_count (running_count),
        .o_waiting_count (waiting_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    pas_outcome_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_opcode        (opcode),
        .i_job_id        (job_id),
        .i_mem_demand    (mem_demand),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_status        (status),
        .i_affected_id   (affected_id),
        .i_promoted      (promoted),
        .i_promoted_id   (promoted_id),
        .i_mem_in_use    (mem_in_use),
        .i_running_count (running_count),
        .i_waiting_count (waiting_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial forever #2 clk = ~clk;

    task automatic offer_request(input t_opcode op, input logic [ID_W-1:0] id,
                                 input logic [MEM_W-1:0] demand);
        int unsigned gap;
        if (requests_sent % 50 == 0)
            steady_sender = ($urandom_range(0, 2) == 0);
        gap = steady_sender ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        opcode     <= op;
        job_id     <= id;
        mem_demand <= demand;
        do @(posedge clk); while (req_stall);
        requests_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic program_limits(input logic [CNT_W-1:0] run_max,
                                  input logic [MEM_W-1:0] mem_total);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_RUNNING;
        cfg_wdata <= MEM_W'(run_max);
        @(posedge clk);
        cfg_index <= CFG_MEMORY_TOTAL;
        cfg_wdata <= mem_total;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_capacity = mem_total;
        settings_applied++;
    endtask

    function automatic logic [MEM_W-1:0] pick_demand(input logic [MEM_W-1:0] cap);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return '0;
            1: return cap;
            2: return (cap == '1) ? cap : cap + 1'b1;
            3: return '1;
            4: return MEM_W'($urandom);
            5, 6, 7: return MEM_W'($urandom_range(0, 3));
            default: return MEM_W'($urandom_range(0, cap / 3));
        endcase
    endfunction

    task automatic random_requests(input int unsigned kill_pct, input int count);
        repeat (count) begin
            if ($urandom_range(1, 100) <= kill_pct)
                offer_request(OP_KILL, ID_W'($urandom), MEM_W'($urandom));
            else
                offer_request(OP_CREATE, ID_W'($urandom), pick_demand(cur_capacity));
        end
    endtask

    // result sink with random stalls and two long hold-offs
    initial begin : result_sink
        int unsigned hold;
        int          taken;
        bit          steady;
        taken  = 0;
        steady = 1'b0;
        wait (rst_n);
        forever begin
            if (taken % 64 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if (taken == 300 || taken == 1100)
                hold = 80;
            else
                hold = steady ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
            taken++;
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0] plan_max[8];
        logic [MEM_W-1:0] plan_mem[8];
        int unsigned      plan_kill[8];
        logic [CNT_W-1:0] run_max;
        logic [MEM_W-1:0] mem_total;
        int unsigned      kill_pct;
        plan_max  = '{5'd16, 5'd0, 5'd16, 5'd1, 5'd4, 5'd16, 5'd2, 5'd8};
        plan_mem  = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd1024, 16'd300, 16'd64, 16'd4000,
                      16'hFFFF};
        plan_kill = '{30, 20, 40, 45, 45, 35, 50, 25};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: four slots, 1024 units
        offer_request(OP_KILL,   16'h1234, 16'hFFFF);
        offer_request(OP_CREATE, 16'h0000, 16'd0);
        offer_request(OP_CREATE, 16'hFFFF, 16'hFFFF);
        offer_request(OP_CREATE, 16'h0001, 16'd1024);
        offer_request(OP_CREATE, 16'h0002, 16'd1);
        offer_request(OP_CREATE, 16'h0003, 16'd0);
        offer_request(OP_CREATE, 16'hAAAA, 16'd1025);
        offer_request(OP_KILL,   16'h0000, 16'h0000);
        offer_request(OP_KILL,   16'h0000, 16'h0000);
        offer_request(OP_CREATE, 16'h5555, 16'd0);
        offer_request(OP_CREATE, 16'h0004, 16'd0);
        offer_request(OP_CREATE, 16'h0005, 16'd0);
        // no slots, and memory below what is held
        wait_drained();
        program_limits(5'd0, 16'd0);
        offer_request(OP_CREATE, 16'h0006, 16'd0);
        offer_request(OP_KILL,   16'hFFFF, 16'h0000);
        wait_drained();
        program_limits(5'd16, 16'd0);
        offer_request(OP_CREATE, 16'h0007, 16'd0);
        offer_request(OP_KILL,   16'h0000, 16'hFFFF);
        offer_request(OP_KILL,   16'h0000, 16'h0000);
        // running count stays above a lowered slot limit
        wait_drained();
        program_limits(5'd1, 16'hFFFF);
        offer_request(OP_KILL,   16'h0000, 16'h0000);
        offer_request(OP_CREATE, 16'hFFFF, 16'hFFFF);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                run_max   = plan_max[p];
                mem_total = plan_mem[p];
                kill_pct  = plan_kill[p];
            end else begin
                run_max   = CNT_W'($urandom_range(0, 16));
                mem_total = ($urandom_range(0, 1) == 0) ? MEM_W'($urandom_range(0, 200))
                                                        : MEM_W'($urandom);
                kill_pct  = $urandom_range(30, 55);
            end
            wait_drained();
            program_limits(run_max, mem_total);
            random_requests(kill_pct, PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("sent %0d requests under %0d limit settings, compared %0d results",
                 requests_sent, settings_applied, checked);
        if (fail_count == 0)
            $display("PASS process_admission_scheduler");
        else
            $display("FAIL process_admission_scheduler");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("FAIL process_admission_scheduler");
        $finish;
    end

endmodule
